@@ design/aesp_pkg.sv @@
// ----------------------------------------------------------------------------
// aesp_pkg: shared types and constants of the escape stream parser
// Holds the byte codes of the escape syntax, the SGR codes, the style and
// result types used by the parser and its SGR decode unit.
// ----------------------------------------------------------------------------
package aesp_pkg;

	// Bytes of the escape syntax.
	localparam logic [7:0] CH_BEL       = 8'h07;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_ESC       = 8'h1B;
	localparam logic [7:0] CH_CSI_OPEN  = 8'h5B;
	localparam logic [7:0] CH_OSC_OPEN  = 8'h5D;
	localparam logic [7:0] CH_SEMI      = 8'h3B;
	localparam logic [7:0] PARAM_LO     = 8'h30;
	localparam logic [7:0] DIGIT_HI     = 8'h39;
	localparam logic [7:0] PARAM_HI     = 8'h3F;
	localparam logic [7:0] INTER_LO     = 8'h20;
	localparam logic [7:0] INTER_HI     = 8'h2F;
	localparam logic [7:0] FINAL_LO     = 8'h40;
	localparam logic [7:0] FINAL_HI     = 8'h7E;
	localparam logic [7:0] FINAL_SGR    = 8'h6D;
	localparam logic [7:0] FINAL_EL     = 8'h4B;
	localparam logic [7:0] FINAL_ED     = 8'h4A;

	// SGR codes.
	localparam int unsigned SGR_RESET      = 0;
	localparam int unsigned SGR_BOLD       = 1;
	localparam int unsigned SGR_DIM        = 2;
	localparam int unsigned SGR_NORMAL     = 22;
	localparam int unsigned SGR_FG_DEFAULT = 39;
	localparam int unsigned SGR_BG_DEFAULT = 49;
	localparam int unsigned SGR_FG_EXT     = 38;
	localparam int unsigned SGR_BG_EXT     = 48;
	localparam int unsigned SGR_FG_BASE    = 30;
	localparam int unsigned SGR_FG_BRIGHT  = 90;
	localparam int unsigned SGR_BG_BASE    = 40;
	localparam int unsigned SGR_BG_BRIGHT  = 100;
	localparam int unsigned SGR_COLOR_SPAN = 7;
	localparam int unsigned BRIGHT_OFFSET  = 8;
	localparam int unsigned EXT_INDEXED    = 5;
	localparam int unsigned EXT_RGB        = 2;

	// Erase-in-line and erase-in-display selectors.
	localparam int unsigned ERASE_TO_END   = 0;
	localparam int unsigned ERASE_TO_BEGIN = 1;
	localparam int unsigned ERASE_ALL      = 2;

	localparam logic signed [4:0] COLOR_DEFAULT = -5'sd1;

	typedef enum logic [2:0] {
		KIND_TEXT        = 3'd0,
		KIND_ERASE_EOL   = 3'd1,
		KIND_ERASE_BOL   = 3'd2,
		KIND_ERASE_LINE  = 3'd3,
		KIND_ERASE_DISP  = 3'd4
	} kind_t;

	typedef struct packed {
		logic signed [4:0] fg;
		logic signed [4:0] bg;
		logic              bold;
		logic              dim;
	} style_t;

	localparam style_t STYLE_DEFAULT = '{fg: COLOR_DEFAULT, bg: COLOR_DEFAULT,
		bold: 1'b0, dim: 1'b0};

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		style_t      style;
	} result_t;

	function automatic result_t text_result(input logic [7:0] ch, input style_t style);
		result_t r;
		r.kind  = KIND_TEXT;
		r.ch    = ch;
		r.style = style;
		return r;
	endfunction

	function automatic result_t erase_result(input kind_t kind);
		result_t r;
		r.kind  = kind;
		r.ch    = 8'h00;
		r.style = STYLE_DEFAULT;
		return r;
	endfunction

endpackage

@@ design/ansi_escape_stream_parser.sv @@
// ----------------------------------------------------------------------------
// ansi_escape_stream_parser: terminal output byte parser with SGR style
// Tracks the escape state of a terminal byte stream, keeps the text style
// and emits text bytes with their style and erase events.
// ----------------------------------------------------------------------------
// Usage: one byte of terminal output enters per item on the s_ channel. Each
// byte causes zero, one or two result items on the m_ channel; tlast marks
// the last result of a byte. A result is either a text byte with the style
// in force (tuser KIND_TEXT) or an erase event with the default style.
// A carriage return is held back: CR LF gives a plain LF text item, a lone
// CR gives an erase-line item ahead of the results of the next byte.
// The first result of a byte is loaded into the output register when the byte
// is taken; a byte with two results blocks input until the second is loaded.
// A CSI 'm' final walks the stored parameters through the shared SGR decode
// unit, each one read from the parameter memory and then decoded, for at most
// MAX_PARAMS of them; no byte is taken while the walk runs.
// Reset brings the parser to ground state with the default style. The
// parameter memory is not cleared, since each entry is written before use.
// When the receiver stalls, the result stays in the output register and the
// next byte is taken as soon as that register is emptied or being emptied.
module ansi_escape_stream_parser import aesp_pkg::*; #(
	parameter int MAX_PARAMS = 16,
	parameter int PARAM_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] char_out, [12:8] fg_color,
	                               // [17:13] bg_color, [18] bold_on,
	                               // [19] dim_on, [23:20] zero
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast    // last result of the byte
);

	localparam int P  = PARAM_BITS;
	localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int CW = $clog2(MAX_PARAMS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARAMS);

	typedef enum logic [3:0] {
		PS_GROUND = 4'b0001,
		PS_ESCAPE = 4'b0010,
		PS_CSI    = 4'b0100,
		PS_OSC    = 4'b1000
	} parse_t;

	typedef enum logic [3:0] {
		SEQ_IDLE  = 4'b0001,
		SEQ_EMIT  = 4'b0010,
		SEQ_READ  = 4'b0100,
		SEQ_APPLY = 4'b1000
	} seq_t;

	// Parser state.
	parse_t          pst_q;
	logic            cr_q;
	logic            osc_esc_q;
	style_t          style_q;
	logic [CW-1:0]   cnt_q;
	logic            stop_q;
	logic            ovf_q;
	logic [P-1:0]    acc_q;
	logic [P-1:0]    p0_q;

	// Sequencer and SGR walk.
	seq_t            seq_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   np_q;
	logic [1:0]      skip_q;
	logic            ext_q;

	// Output register and second-result hold.
	result_t         out_q;
	logic            out_last_q;
	logic            out_valid_q;
	result_t         hold_q;

	logic [7:0]      c;
	logic            accept;
	logic            out_free;
	logic            load_out;

	parse_t          pst_d;
	logic            cr_d;
	logic            osc_d;
	logic [CW-1:0]   cnt_d;
	logic            stop_d;
	logic            ovf_d;
	logic [P-1:0]    acc_d;
	logic [P-1:0]    p0_d;
	logic            emit_b;
	result_t         res_b;
	logic            ram_we;
	logic            walk_go;
	logic            lf_after_cr;

	result_t         r0;
	result_t         r1;
	logic            have0;
	logic            have1;

	logic [P+3:0]    acc_wide;
	logic [P+3:0]    acc10;
	logic            acc_ovf;
	logic [P-1:0]    p0;

	logic [P-1:0]    rdata;
	style_t          style_nx;
	logic            ext_color;
	logic [CW-1:0]   idx_n;
	logic            walk_stop;

	assign c        = s_tdata;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (seq_q == SEQ_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	// Decimal accumulation of the parameter being collected.
	assign acc_wide = {4'b0000, acc_q};
	assign acc10    = (acc_wide << 3) + (acc_wide << 1) + (P + 4)'(c[3:0]);
	assign acc_ovf  = |acc10[P+3:P];
	assign p0       = (cnt_q == '0) ? acc_q : p0_q;

	always_comb begin
		pst_d       = pst_q;
		cr_d        = cr_q;
		osc_d       = osc_esc_q;
		cnt_d       = cnt_q;
		stop_d      = stop_q;
		ovf_d       = ovf_q;
		acc_d       = acc_q;
		p0_d        = p0_q;
		emit_b      = 1'b0;
		res_b       = text_result(c, style_q);
		ram_we      = 1'b0;
		walk_go     = 1'b0;
		lf_after_cr = 1'b0;

		if (cr_q) begin
			cr_d = 1'b0;
			if (c == CH_LF) begin
				lf_after_cr = 1'b1;
			end
		end

		if (!lf_after_cr) begin
			case (pst_q)
				PS_GROUND: begin
					if (c == CH_ESC) begin
						pst_d = PS_ESCAPE;
					end else if (c == CH_CR) begin
						cr_d = 1'b1;
					end else begin
						emit_b = 1'b1;
					end
				end
				PS_ESCAPE: begin
					if (c == CH_CSI_OPEN) begin
						pst_d  = PS_CSI;
						cnt_d  = '0;
						acc_d  = '0;
						stop_d = 1'b0;
						ovf_d  = 1'b0;
					end else if (c == CH_OSC_OPEN) begin
						pst_d = PS_OSC;
						osc_d = 1'b0;
					end else begin
						// An unknown escape drops the ESC and treats the byte as ground.
						pst_d = PS_GROUND;
						if (c == CH_ESC) begin
							pst_d = PS_ESCAPE;
						end else if (c == CH_CR) begin
							cr_d = 1'b1;
						end else begin
							emit_b = 1'b1;
						end
					end
				end
				PS_CSI: begin
					if (c >= PARAM_LO && c <= PARAM_HI) begin
						if (c == CH_SEMI) begin
							if (cnt_q < CNT_MAX) begin
								ram_we = 1'b1;
								cnt_d  = cnt_q + 1'b1;
								if (cnt_q == '0) begin
									p0_d = acc_q;
								end
							end
							acc_d  = '0;
							stop_d = 1'b0;
							ovf_d  = 1'b0;
						end else if (c <= DIGIT_HI) begin
							if (!stop_q && !ovf_q && cnt_q < CNT_MAX) begin
								if (acc_ovf) begin
									ovf_d = 1'b1;
									acc_d = '0;
								end else begin
									acc_d = acc10[P-1:0];
								end
							end
						end else begin
							stop_d = 1'b1;
						end
					end else if (c >= INTER_LO && c <= INTER_HI) begin
						pst_d = PS_CSI;
					end else if (c >= FINAL_LO && c <= FINAL_HI) begin
						pst_d = PS_GROUND;
						if (c == FINAL_SGR) begin
							ram_we  = (cnt_q < CNT_MAX);
							walk_go = 1'b1;
						end else if (c == FINAL_EL) begin
							if (p0 == P'(ERASE_TO_END)) begin
								emit_b = 1'b1;
								res_b  = erase_result(KIND_ERASE_EOL);
							end else if (p0 == P'(ERASE_TO_BEGIN)) begin
								emit_b = 1'b1;
								res_b  = erase_result(KIND_ERASE_BOL);
							end else if (p0 == P'(ERASE_ALL)) begin
								emit_b = 1'b1;
								res_b  = erase_result(KIND_ERASE_LINE);
							end
						end else if (c == FINAL_ED) begin
							emit_b = 1'b1;
							res_b  = erase_result((p0 >= P'(ERASE_ALL)) ?
								KIND_ERASE_DISP : KIND_ERASE_EOL);
						end
					end else begin
						// A stray byte ends the sequence and passes as text.
						pst_d  = PS_GROUND;
						emit_b = 1'b1;
					end
				end
				PS_OSC: begin
					if (c == CH_BEL) begin
						pst_d = PS_GROUND;
					end else if (osc_esc_q) begin
						osc_d = 1'b0;
						pst_d = PS_GROUND;
					end else if (c == CH_ESC) begin
						osc_d = 1'b1;
					end
				end
				default: begin
					pst_d = PS_GROUND;
				end
			endcase
		end

		// Order the results: a pending CR event always goes first.
		if (cr_q) begin
			r0    = lf_after_cr ? text_result(c, style_q) : erase_result(KIND_ERASE_LINE);
			have0 = 1'b1;
			r1    = res_b;
			have1 = emit_b;
		end else begin
			r0    = res_b;
			have0 = emit_b;
			r1    = res_b;
			have1 = 1'b0;
		end
	end

	assign load_out = (accept && have0) || (seq_q == SEQ_EMIT && out_free);

	// Parameter store and the shared SGR decode unit.
	aesp_ram #(
		.WIDTH (P),
		.DEPTH (MAX_PARAMS)
	) u_params (
		.clk   (clk),
		.we    (accept && ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (acc_q),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	aesp_sgr_unit #(
		.PARAM_BITS (P)
	) u_sgr (
		.code      (rdata),
		.style_cur (style_q),
		.style_nx  (style_nx),
		.ext_color (ext_color)
	);

	assign idx_n     = idx_q + 1'b1;
	assign walk_stop = (skip_q == 2'd0) && ext_q
		&& rdata != P'(EXT_INDEXED) && rdata != P'(EXT_RGB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pst_q       <= PS_GROUND;
			cr_q        <= 1'b0;
			osc_esc_q   <= 1'b0;
			style_q     <= STYLE_DEFAULT;
			cnt_q       <= '0;
			stop_q      <= 1'b0;
			ovf_q       <= 1'b0;
			seq_q       <= SEQ_IDLE;
			idx_q       <= '0;
			np_q        <= '0;
			skip_q      <= 2'd0;
			ext_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (seq_q)
				SEQ_IDLE: begin
					if (accept) begin
						pst_q     <= pst_d;
						cr_q      <= cr_d;
						osc_esc_q <= osc_d;
						cnt_q     <= cnt_d;
						stop_q    <= stop_d;
						ovf_q     <= ovf_d;
						if (have1) begin
							seq_q <= SEQ_EMIT;
						end else if (walk_go) begin
							seq_q  <= SEQ_READ;
							idx_q  <= '0;
							np_q   <= (cnt_q < CNT_MAX) ? cnt_q + 1'b1 : CNT_MAX;
							skip_q <= 2'd0;
							ext_q  <= 1'b0;
						end
					end
				end
				SEQ_EMIT: begin
					if (out_free) begin
						seq_q <= SEQ_IDLE;
					end
				end
				SEQ_READ: begin
					seq_q <= SEQ_APPLY;
				end
				SEQ_APPLY: begin
					if (skip_q != 2'd0) begin
						skip_q <= skip_q - 2'd1;
					end else if (ext_q) begin
						ext_q <= 1'b0;
						if (rdata == P'(EXT_INDEXED)) begin
							skip_q <= 2'd1;
						end else if (rdata == P'(EXT_RGB)) begin
							skip_q <= 2'd3;
						end
					end else if (ext_color) begin
						ext_q <= 1'b1;
					end else begin
						style_q <= style_nx;
					end
					idx_q <= idx_n;
					seq_q <= (walk_stop || idx_n >= np_q) ? SEQ_IDLE : SEQ_READ;
				end
				default: begin
					seq_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= acc_d;
			p0_q  <= p0_d;
		end
		if (accept && have0) begin
			out_q      <= r0;
			out_last_q <= !have1;
		end else if (seq_q == SEQ_EMIT && out_free) begin
			out_q      <= hold_q;
			out_last_q <= 1'b1;
		end
		if (accept && have1) begin
			hold_q <= r1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {4'b0000, out_q.style.dim, out_q.style.bold, out_q.style.bg,
		out_q.style.fg, out_q.ch};

	// While a second result waits, the first one still sits unsent in the output.
	a_emit_holds_first: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SEQ_EMIT |-> out_valid_q && !out_last_q)
		else $error("second result pending without a first result in the output");

	// Erase results carry the default style.
	a_erase_default: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind != KIND_TEXT |->
		out_q.style == STYLE_DEFAULT && out_q.ch == 8'h00)
		else $error("erase result with a non-default style");

	// The SGR walk never decodes past the collected parameters.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SEQ_APPLY |-> idx_q < np_q && np_q <= CNT_MAX)
		else $error("SGR walk beyond the parameter count");

	// The parameter index saturates at the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("parameter count above the store depth");

	// No input item is taken while the walk or a second result is in progress.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> $past(seq_q) == SEQ_IDLE)
		else $error("input taken while the sequencer was busy");

endmodule

@@ design/aesp_ram.sv @@
// ----------------------------------------------------------------------------
// aesp_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module aesp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/aesp_sgr_unit.sv @@
// ----------------------------------------------------------------------------
// aesp_sgr_unit: decode of one SGR parameter
// Compares one stored parameter against the SGR codes and returns the style
// that results, or flags the start of an extended color.
// ----------------------------------------------------------------------------
module aesp_sgr_unit import aesp_pkg::*; #(
	parameter int PARAM_BITS = 16
) (
	input  logic [PARAM_BITS-1:0] code,
	input  style_t                style_cur,
	output style_t                style_nx,
	output logic                  ext_color
);

	localparam int P = PARAM_BITS;

	always_comb begin
		style_nx  = style_cur;
		ext_color = 1'b0;
		if (code == P'(SGR_RESET)) begin
			style_nx = STYLE_DEFAULT;
		end else if (code == P'(SGR_BOLD)) begin
			style_nx.bold = 1'b1;
		end else if (code == P'(SGR_DIM)) begin
			style_nx.dim = 1'b1;
		end else if (code == P'(SGR_NORMAL)) begin
			style_nx.bold = 1'b0;
			style_nx.dim  = 1'b0;
		end else if (code == P'(SGR_FG_DEFAULT)) begin
			style_nx.fg = COLOR_DEFAULT;
		end else if (code == P'(SGR_BG_DEFAULT)) begin
			style_nx.bg = COLOR_DEFAULT;
		end else if (code == P'(SGR_FG_EXT) || code == P'(SGR_BG_EXT)) begin
			ext_color = 1'b1;
		end else if (code >= P'(SGR_FG_BASE)
				&& code <= P'(SGR_FG_BASE + SGR_COLOR_SPAN)) begin
			style_nx.fg = 5'(code - P'(SGR_FG_BASE));
		end else if (code >= P'(SGR_FG_BRIGHT)
				&& code <= P'(SGR_FG_BRIGHT + SGR_COLOR_SPAN)) begin
			style_nx.fg = 5'(code - P'(SGR_FG_BRIGHT) + P'(BRIGHT_OFFSET));
		end else if (code >= P'(SGR_BG_BASE)
				&& code <= P'(SGR_BG_BASE + SGR_COLOR_SPAN)) begin
			style_nx.bg = 5'(code - P'(SGR_BG_BASE));
		end else if (code >= P'(SGR_BG_BRIGHT)
				&& code <= P'(SGR_BG_BRIGHT + SGR_COLOR_SPAN)) begin
			style_nx.bg = 5'(code - P'(SGR_BG_BRIGHT) + P'(BRIGHT_OFFSET));
		end
	end

endmodule
